### hdl/blr_pkg.sv
// shared types and constants of the line rasterizer
`default_nettype none

package blr_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int SURF_BITS      = 12;
   localparam int COLOR_BITS     = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [SURF_BITS-1:0] SURF_WIDTH_RESET  = SURF_BITS'(640);
   localparam logic [SURF_BITS-1:0] SURF_HEIGHT_RESET = SURF_BITS'(480);

   localparam logic REG_SURF_WIDTH  = 1'b0;
   localparam logic REG_SURF_HEIGHT = 1'b1;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_STEP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      OCT_STEEP_INC   = 2'd0,
      OCT_SHALLOW_INC = 2'd1,
      OCT_STEEP_DEC   = 2'd2,
      OCT_SHALLOW_DEC = 2'd3
   } octant_type;

   typedef struct packed {
      logic       is_load;
      octant_type octant;
   } blr_cmd_type;

endpackage

`default_nettype wire

### hdl/blr_front.sv
// front end: classifies items and computes line setup for loads
`default_nettype none

module blr_front #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
   parameter int ERR_BITS   = blr_pkg::COORD_BITS_DEF + 4
) (
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_kind,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic                         push_valid,
   input  logic                         push_ready,
   output blr_pkg::blr_cmd_type         push_cmd,
   output logic signed [COORD_BITS-1:0] push_x,
   output logic signed [COORD_BITS-1:0] push_y,
   output logic signed [COORD_BITS-1:0] push_stop,
   output logic signed [ERR_BITS-1:0]   push_err,
   output logic signed [ERR_BITS-1:0]   push_hold,
   output logic signed [ERR_BITS-1:0]   push_move
);

   logic                         swap;
   logic signed [COORD_BITS-1:0] ax, ay, bx, by;
   logic signed [COORD_BITS:0]   dxs, dys;
   logic        [COORD_BITS:0]   dx_mag, dy_mag;
   logic signed [ERR_BITS-1:0]   dx_e, dy_e;
   logic                         steep;
   logic                         xneg;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;

   always_comb begin
      swap = end_y < start_y;
      ax = swap ? end_x : start_x;
      ay = swap ? end_y : start_y;
      bx = swap ? start_x : end_x;
      by = swap ? start_y : end_y;
      dxs = $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
      dys = $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
      xneg = dxs[COORD_BITS];
      dx_mag = xneg ? $unsigned(-dxs) : $unsigned(dxs);
      dy_mag = $unsigned(dys);
      steep = dy_mag > dx_mag;
      dx_e = $signed({{(ERR_BITS-COORD_BITS-1){1'b0}}, dx_mag});
      dy_e = $signed({{(ERR_BITS-COORD_BITS-1){1'b0}}, dy_mag});

      push_cmd.is_load = (in_kind == blr_pkg::KIND_LOAD);
      push_x = ax;
      push_y = ay;
      push_move = (dy_e <<< 1) - (dx_e <<< 1);
      if (steep) begin
         push_cmd.octant = xneg ? blr_pkg::OCT_STEEP_DEC : blr_pkg::OCT_STEEP_INC;
         push_err  = dy_e - (dx_e <<< 1);
         push_hold = -(dx_e <<< 1);
         push_stop = by;
      end else begin
         push_cmd.octant = xneg ? blr_pkg::OCT_SHALLOW_DEC : blr_pkg::OCT_SHALLOW_INC;
         push_err  = (dy_e <<< 1) - dx_e;
         push_hold = dy_e <<< 1;
         push_stop = bx;
      end
   end

endmodule

`default_nettype wire

### hdl/blr_queue.sv
// short command queue between front and back
`default_nettype none

module blr_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = blr_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  blr_pkg::blr_cmd_type push_cmd,
   input  logic [DATA_W-1:0]    push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output blr_pkg::blr_cmd_type pop_cmd,
   output logic [DATA_W-1:0]    pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   blr_pkg::blr_cmd_type cmd_mem_ff [DEPTH];
   logic [DATA_W-1:0]    data_mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = cmd_mem_ff[rd_ptr_ff];
   assign pop_data   = data_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem_ff[wr_ptr_ff]  <= push_cmd;
         data_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/blr_back.sv
// back end: line stepping state, clip test and result register
`default_nettype none

module blr_back #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
   parameter int ERR_BITS   = blr_pkg::COORD_BITS_DEF + 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  blr_pkg::blr_cmd_type                 cmd,
   input  logic signed [COORD_BITS-1:0]         ld_x,
   input  logic signed [COORD_BITS-1:0]         ld_y,
   input  logic signed [COORD_BITS-1:0]         ld_stop,
   input  logic signed [ERR_BITS-1:0]           ld_err,
   input  logic signed [ERR_BITS-1:0]           ld_hold,
   input  logic signed [ERR_BITS-1:0]           ld_move,
   input  logic [blr_pkg::COLOR_BITS-1:0]       ld_color,
   input  logic [blr_pkg::SURF_BITS-1:0]        surf_width,
   input  logic [blr_pkg::SURF_BITS-1:0]        surf_height,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [COORD_BITS-1:0]         out_x,
   output logic signed [COORD_BITS-1:0]         out_y,
   output logic [blr_pkg::COLOR_BITS-1:0]       out_color,
   output logic                                 out_inside,
   output logic                                 out_last
);

   localparam int CMP_W = COORD_BITS + blr_pkg::SURF_BITS;

   logic                              busy_ff, busy_in;
   logic signed [COORD_BITS-1:0]      cursor_x_ff, cursor_x_in;
   logic signed [COORD_BITS-1:0]      cursor_y_ff, cursor_y_in;
   logic signed [COORD_BITS-1:0]      stop_ff, stop_in;
   logic signed [ERR_BITS-1:0]        err_ff, err_in;
   logic signed [ERR_BITS-1:0]        hold_ff, hold_in;
   logic signed [ERR_BITS-1:0]        move_ff, move_in;
   blr_pkg::octant_type               octant_ff, octant_in;
   logic [blr_pkg::COLOR_BITS-1:0]    color_ff, color_in;

   logic                              out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0]      out_x_ff;
   logic signed [COORD_BITS-1:0]      out_y_ff;
   logic [blr_pkg::COLOR_BITS-1:0]    out_color_ff;
   logic                              out_inside_ff;
   logic                              out_last_ff;

   logic                              pop, emit, steep, dec, at_last, in_surf, err_pos;
   logic signed [COORD_BITS-1:0]      x_next;

   assign pop_ready  = !out_valid_ff || out_ready;
   assign pop        = pop_valid && pop_ready;
   assign emit       = pop && !cmd.is_load && busy_ff;

   assign out_valid  = out_valid_ff;
   assign out_x      = out_x_ff;
   assign out_y      = out_y_ff;
   assign out_color  = out_color_ff;
   assign out_inside = out_inside_ff;
   assign out_last   = out_last_ff;

   always_comb begin
      steep = (octant_ff == blr_pkg::OCT_STEEP_INC) || (octant_ff == blr_pkg::OCT_STEEP_DEC);
      dec   = (octant_ff == blr_pkg::OCT_STEEP_DEC) || (octant_ff == blr_pkg::OCT_SHALLOW_DEC);
      at_last = steep ? (cursor_y_ff == stop_ff) : (cursor_x_ff == stop_ff);
      in_surf = !cursor_x_ff[COORD_BITS-1] && !cursor_y_ff[COORD_BITS-1] &&
                ({{blr_pkg::SURF_BITS{1'b0}}, cursor_x_ff} <
                 CMP_W'({{COORD_BITS{1'b0}}, surf_width})) &&
                ({{blr_pkg::SURF_BITS{1'b0}}, cursor_y_ff} <
                 CMP_W'({{COORD_BITS{1'b0}}, surf_height}));
      err_pos = !err_ff[ERR_BITS-1] && (err_ff != '0);
      x_next  = dec ? cursor_x_ff - 1'b1 : cursor_x_ff + 1'b1;

      busy_in     = busy_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      stop_in     = stop_ff;
      err_in      = err_ff;
      hold_in     = hold_ff;
      move_in     = move_ff;
      octant_in   = octant_ff;
      color_in    = color_ff;

      if (pop && cmd.is_load) begin
         busy_in     = 1'b1;
         cursor_x_in = ld_x;
         cursor_y_in = ld_y;
         stop_in     = ld_stop;
         err_in      = ld_err;
         hold_in     = ld_hold;
         move_in     = ld_move;
         octant_in   = cmd.octant;
         color_in    = ld_color;
      end else if (emit) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else if (steep) begin
            cursor_y_in = cursor_y_ff + 1'b1;
            if (err_pos) begin
               err_in = err_ff + hold_ff;
            end else begin
               cursor_x_in = x_next;
               err_in      = err_ff + move_ff;
            end
         end else begin
            cursor_x_in = x_next;
            if (err_pos) begin
               cursor_y_in = cursor_y_ff + 1'b1;
               err_in      = err_ff + move_ff;
            end else begin
               err_in = err_ff + hold_ff;
            end
         end
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_x_ff <= cursor_x_in;
      cursor_y_ff <= cursor_y_in;
      stop_ff     <= stop_in;
      err_ff      <= err_in;
      hold_ff     <= hold_in;
      move_ff     <= move_in;
      octant_ff   <= octant_in;
      color_ff    <= color_in;
      if (emit) begin
         out_x_ff      <= cursor_x_ff;
         out_y_ff      <= cursor_y_ff;
         out_color_ff  <= color_ff;
         out_inside_ff <= in_surf;
         out_last_ff   <= at_last;
      end
   end

   a_load_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.is_load) |=> busy_ff)
      else $error("load did not start a line");

   a_last_clears_busy: assert property (@(posedge clock) disable iff (reset)
      (emit && at_last) |=> !busy_ff)
      else $error("line still busy after its last pixel");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(pop && !cmd.is_load && busy_ff))
      else $error("result without a step on a busy line");

   a_steep_y_advance: assert property (@(posedge clock) disable iff (reset)
      (emit && !at_last && steep) |=> (cursor_y_ff == $past(cursor_y_ff) + 1'b1))
      else $error("steep line did not advance y");

endmodule

`default_nettype wire

### hdl/bresenham_line_rasterizer_top.sv
// Line rasterizer: a load beat latches two endpoints and a color, and each following step
// beat up to the final pixel returns one pixel of that line with its clip flag, tlast on
// the final pixel. A beat is taken every clock while the queue has room; a load beat gives
// no result and a step beat's pixel passes the queue and the result register. The rate of
// one beat per clock without rsp back-pressure comes from the back end's single error-term
// update, one cursor advance per step. Surface width/height: CSR byte addresses 0 and 4.
`default_nettype none

module bresenham_line_rasterizer_top #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
   localparam int REQ_W = ((4 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + blr_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, end_x, end_y, line_color
   input  logic [REQ_W-1:0]                  req_tdata,
   // kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_x, pixel_y, pixel_color
   output logic [RSP_W-1:0]                  rsp_tdata,
   // inside_res
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [blr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [blr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [blr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int ERR_BITS = COORD_BITS + 4;
   localparam int C        = COORD_BITS;
   localparam int Q_W      = 3 * COORD_BITS + 3 * ERR_BITS + blr_pkg::COLOR_BITS;

   logic [blr_pkg::SURF_BITS-1:0] surf_width_ff, surf_width_in;
   logic [blr_pkg::SURF_BITS-1:0] surf_height_ff, surf_height_in;
   logic                          csr_write;
   logic                          csr_idx;

   logic                          push_valid, push_ready, pop_valid, pop_ready;
   blr_pkg::blr_cmd_type          push_cmd, pop_cmd;
   logic signed [C-1:0]           f_x, f_y, f_stop;
   logic signed [ERR_BITS-1:0]    f_err, f_hold, f_move;
   logic [Q_W-1:0]                push_data, pop_data;

   logic signed [C-1:0]           out_x, out_y;
   logic [blr_pkg::COLOR_BITS-1:0] out_color;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      surf_width_in  = surf_width_ff;
      surf_height_in = surf_height_ff;
      if (csr_write) begin
         case (csr_idx)
            blr_pkg::REG_SURF_WIDTH:  surf_width_in  = csr_pwdata[blr_pkg::SURF_BITS-1:0];
            blr_pkg::REG_SURF_HEIGHT: surf_height_in = csr_pwdata[blr_pkg::SURF_BITS-1:0];
            default: ;
         endcase
      end
      case (csr_idx)
         blr_pkg::REG_SURF_WIDTH:  csr_prdata = blr_pkg::CSR_DATA_W'(surf_width_ff);
         blr_pkg::REG_SURF_HEIGHT: csr_prdata = blr_pkg::CSR_DATA_W'(surf_height_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_width_ff  <= blr_pkg::SURF_WIDTH_RESET;
         surf_height_ff <= blr_pkg::SURF_HEIGHT_RESET;
      end else begin
         surf_width_ff  <= surf_width_in;
         surf_height_ff <= surf_height_in;
      end
   end

   blr_front #(
      .COORD_BITS (COORD_BITS),
      .ERR_BITS   (ERR_BITS)
   ) u_front (
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .start_x    ($signed(req_tdata[C-1:0])),
      .start_y    ($signed(req_tdata[2*C-1:C])),
      .end_x      ($signed(req_tdata[3*C-1:2*C])),
      .end_y      ($signed(req_tdata[4*C-1:3*C])),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .push_x     (f_x),
      .push_y     (f_y),
      .push_stop  (f_stop),
      .push_err   (f_err),
      .push_hold  (f_hold),
      .push_move  (f_move)
   );

   assign push_data = {req_tdata[4*C+blr_pkg::COLOR_BITS-1:4*C],
                       f_move, f_hold, f_err, f_stop, f_y, f_x};

   blr_queue #(
      .DATA_W (Q_W),
      .DEPTH  (blr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .pop_data   (pop_data)
   );

   blr_back #(
      .COORD_BITS (COORD_BITS),
      .ERR_BITS   (ERR_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .cmd         (pop_cmd),
      .ld_x        ($signed(pop_data[C-1:0])),
      .ld_y        ($signed(pop_data[2*C-1:C])),
      .ld_stop     ($signed(pop_data[3*C-1:2*C])),
      .ld_err      ($signed(pop_data[3*C+ERR_BITS-1:3*C])),
      .ld_hold     ($signed(pop_data[3*C+2*ERR_BITS-1:3*C+ERR_BITS])),
      .ld_move     ($signed(pop_data[3*C+3*ERR_BITS-1:3*C+2*ERR_BITS])),
      .ld_color    (pop_data[Q_W-1:3*C+3*ERR_BITS]),
      .surf_width  (surf_width_ff),
      .surf_height (surf_height_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_x       (out_x),
      .out_y       (out_y),
      .out_color   (out_color),
      .out_inside  (rsp_tuser),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({out_color, out_y, out_x});

endmodule

`default_nettype wire
